/* rtl/core/bpu_pkg.sv */
// ----------------------------------------------------------------------------
// bpu_pkg
// Shared types and codes for the bitmap pixel unpacker: channel payloads,
// command and mode codes, register indexes, palette write bundle.
// ----------------------------------------------------------------------------
package bpu_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // command codes on the input channel
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_PAL_WR = 2'd1;
  localparam logic [1:0] FUNC_DATA   = 2'd2;

  // pixel_mode codes
  localparam logic [2:0] MODE_BGR24  = 3'd0;
  localparam logic [2:0] MODE_PAL8   = 3'd1;
  localparam logic [2:0] MODE_PAL4   = 3'd2;
  localparam logic [2:0] MODE_PAL1   = 3'd3;
  localparam logic [2:0] MODE_RGB565 = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIMMING      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd3;

  localparam logic [7:0] DIM_FULL = 8'd255;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  data_byte;
    logic [7:0]  palette_index;
    logic [23:0] palette_color;
  } in_t;

  typedef struct packed {
    logic [14:0] pixel_address;
    logic [15:0] pixel_color;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic        en;
    logic [7:0]  addr;
    logic [23:0] data;
  } pal_wr_t;

endpackage

/* rtl/core/bpu_palette_ram.sv */
// ----------------------------------------------------------------------------
// bpu_palette_ram
// Palette store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bpu_palette_ram #(
  parameter int DEPTH = 256
) (
  input  logic              clk,
  input  bpu_pkg::pal_wr_t  wr,
  input  logic              rd_en,
  input  logic [7:0]        rd_addr,
  output logic [23:0]       rd_data
);
  import bpu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [23:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr[AW-1:0]];
    end
  end

endmodule

/* rtl/core/bitmap_pixel_unpacker_top.sv */
// ----------------------------------------------------------------------------
// bitmap_pixel_unpacker_top
// Turns BMP / raw RGB565 pixel bytes into centered, dimmed RGB565 frame writes.
// ----------------------------------------------------------------------------
// Start and palette-write transactions are handled in S_IDLE, as is a data
// byte that is ignored. An accepted data byte runs through S_PIX, S_ADDR and
// S_EMIT for each pixel it carries (1 to 8), with S_MUL between S_ADDR and
// S_EMIT when dimming is below 255 and the pixel lands in the frame; the first
// pixel past the row width goes from S_PIX to S_END and ends the byte. S_END
// closes every accepted byte; output stalls can hold S_EMIT and S_END. A single
// multiplier is shared for the frame address (row times display width) and the
// three color channel scalings; the palette read is issued in the same cycle
// as the address product. The input is stalled while a byte is being worked
// on; up to one finished result waits in the output register while the next
// transaction is taken.
module bitmap_pixel_unpacker_top #(
  parameter int DISPLAY_WIDTH  = 135,
  parameter int DISPLAY_HEIGHT = 240,
  parameter int PALETTE_DEPTH  = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  bpu_pkg::in_t                       in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output bpu_pkg::out_t                      out_data,
  input  logic                               cfg_we,
  input  logic [bpu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bpu_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import bpu_pkg::*;

  localparam int         FRAME = DISPLAY_WIDTH * DISPLAY_HEIGHT;
  localparam logic [9:0] DW10  = 10'(DISPLAY_WIDTH);
  localparam logic [9:0] DH10  = 10'(DISPLAY_HEIGHT);

  typedef enum logic [2:0] {
    S_IDLE, S_PIX, S_ADDR, S_MUL, S_EMIT, S_END
  } state_t;

  state_t state_r, state_nxt;

  logic [2:0]  mode_r, mode_nxt;
  logic [7:0]  dim_r, dim_nxt;
  logic [9:0]  width_r, width_nxt;
  logic [9:0]  height_r, height_nxt;

  logic [9:0]  row_r, row_nxt;
  logic [9:0]  col_r, col_nxt;
  logic [11:0] lbc_r, lbc_nxt;
  logic [15:0] part_r, part_nxt;
  logic [1:0]  phase_r, phase_nxt;
  logic        done_r, done_nxt;

  logic [7:0]  byte_r, byte_nxt;
  logic [3:0]  npix_r, npix_nxt;
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  cnt_r, cnt_nxt;

  logic signed [22:0] prod_r, prod_nxt;
  logic        pal_ok_r, pal_ok_nxt;
  logic        ok_r, ok_nxt;
  logic [14:0] addr_r, addr_nxt;
  logic [15:0] color_r, color_nxt;
  logic [7:0]  ch0_r, ch0_nxt, ch1_r, ch1_nxt, ch2_r, ch2_nxt;
  logic [7:0]  q0_r, q0_nxt, q1_r, q1_nxt;

  logic        hold_valid_r, hold_valid_nxt;
  out_t        hold_r, hold_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_t        out_r, out_nxt;

  // shared multiplier operands
  logic signed [11:0] mul_a;
  logic [9:0]         mul_b;

  logic        in_acc, out_free;
  pal_wr_t     pal_wr;
  logic        pal_rd_en;
  logic [7:0]  pidx;
  logic [23:0] pal_rd_data, pc;

  logic signed [10:0] dx, dy, dx_adj, dy_adj, x_off, y_off;
  logic signed [11:0] row_off, col_off;
  logic signed [23:0] idx;
  logic               idx_ok;

  logic [14:0] bw;
  logic [9:0]  lsz_words;
  logic [13:0] lsize;
  logic [11:0] lbc_inc;

  logic [7:0]  cr, cg, cb;
  logic [15:0] c565;
  logic [7:0]  chsel;

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  bpu_palette_ram #(.DEPTH(PALETTE_DEPTH)) u_pal (
    .clk     (clk),
    .wr      (pal_wr),
    .rd_en   (pal_rd_en),
    .rd_addr (pidx),
    .rd_data (pal_rd_data)
  );

  // centering offsets, truncated toward zero
  always_comb begin
    dx      = $signed({1'b0, DW10}) - $signed({1'b0, width_r});
    dy      = $signed({1'b0, DH10}) - $signed({1'b0, height_r});
    dx_adj  = dx + $signed({10'b0, dx[10]});
    dy_adj  = dy + $signed({10'b0, dy[10]});
    x_off   = dx_adj >>> 1;
    y_off   = dy_adj >>> 1;
    row_off = $signed({2'b00, row_r}) + $signed({y_off[10], y_off});
    col_off = $signed({2'b00, col_r}) + $signed({x_off[10], x_off});
    idx     = $signed({prod_r[22], prod_r}) + $signed({{12{col_off[11]}}, col_off});
    idx_ok  = !idx[23] && (idx < $signed(24'(FRAME)));
  end

  // line size in bytes, padded to whole words in the BMP modes
  always_comb begin
    case (mode_r)
      MODE_BGR24: bw = ({5'b0, width_r} << 4) + ({5'b0, width_r} << 3);
      MODE_PAL8:  bw = {5'b0, width_r} << 3;
      MODE_PAL4:  bw = {5'b0, width_r} << 2;
      default:    bw = {5'b0, width_r};
    endcase
    lsz_words = 10'((bw + 15'd31) >> 5);
    if (mode_r == MODE_RGB565) begin
      lsize = {3'b000, width_r, 1'b0};
    end else begin
      lsize = {2'b00, lsz_words, 2'b00};
    end
    lbc_inc = lbc_r + 12'd1;
  end

  // palette index of the current pixel
  always_comb begin
    case (mode_r)
      MODE_PAL8: pidx = byte_r;
      MODE_PAL4: pidx = (k_r == 3'd0) ? {4'b0, byte_r[7:4]} : {4'b0, byte_r[3:0]};
      MODE_PAL1: pidx = {7'b0, byte_r[~k_r]};
      default:   pidx = 8'd0;
    endcase
  end

  // base color and dimming operands of the current pixel
  always_comb begin
    pc = pal_ok_r ? pal_rd_data : 24'd0;
    case (mode_r)
      MODE_BGR24: begin
        cr = byte_r;
        cg = part_r[15:8];
        cb = part_r[7:0];
      end
      default: begin
        cr = pc[23:16];
        cg = pc[15:8];
        cb = pc[7:0];
      end
    endcase
    if (mode_r == MODE_RGB565) begin
      c565 = {byte_r, part_r[7:0]};
    end else begin
      c565 = {cr[7:3], cg[7:2], cb[7:3]};
    end
  end

  always_comb begin
    case (cnt_r)
      2'd0:    chsel = ch0_r;
      2'd1:    chsel = ch1_r;
      2'd2:    chsel = ch2_r;
      default: chsel = 8'd0;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    dim_nxt        = dim_r;
    width_nxt      = width_r;
    height_nxt     = height_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    lbc_nxt        = lbc_r;
    part_nxt       = part_r;
    phase_nxt      = phase_r;
    done_nxt       = done_r;
    byte_nxt       = byte_r;
    npix_nxt       = npix_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    pal_ok_nxt     = pal_ok_r;
    ok_nxt         = ok_r;
    addr_nxt       = addr_r;
    color_nxt      = color_r;
    ch0_nxt        = ch0_r;
    ch1_nxt        = ch1_r;
    ch2_nxt        = ch2_r;
    q0_nxt         = q0_r;
    q1_nxt         = q1_r;
    hold_valid_nxt = hold_valid_r;
    hold_nxt       = hold_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    mul_a          = 12'sd0;
    mul_b          = 10'd0;
    pal_rd_en      = 1'b0;
    pal_wr.en      = 1'b0;
    pal_wr.addr    = in_data.palette_index;
    pal_wr.data    = in_data.palette_color;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_PIXEL_MODE:   mode_nxt   = cfg_wdata[2:0];
        CFG_DIMMING:      dim_nxt    = cfg_wdata[7:0];
        CFG_IMAGE_WIDTH:  width_nxt  = cfg_wdata;
        CFG_IMAGE_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc && mode_r <= MODE_RGB565) begin
          unique case (in_data.func)
            FUNC_START: begin
              col_nxt   = 10'd0;
              lbc_nxt   = 12'd0;
              part_nxt  = 16'd0;
              phase_nxt = 2'd0;
              row_nxt   = (mode_r == MODE_RGB565 || height_r == 10'd0) ?
                          10'd0 : height_r - 10'd1;
              done_nxt  = (width_r == 10'd0 || height_r == 10'd0);
            end
            FUNC_PAL_WR: begin
              pal_wr.en = ({1'b0, in_data.palette_index} < 9'(PALETTE_DEPTH));
            end
            FUNC_DATA: begin
              if (!done_r) begin
                byte_nxt = in_data.data_byte;
                k_nxt    = 3'd0;
                npix_nxt = 4'd0;
                case (mode_r)
                  MODE_BGR24: begin
                    if (phase_r == 2'd0) begin
                      part_nxt  = {8'h00, in_data.data_byte};
                      phase_nxt = 2'd1;
                    end else if (phase_r == 2'd1) begin
                      part_nxt  = {in_data.data_byte, part_r[7:0]};
                      phase_nxt = 2'd2;
                    end else begin
                      npix_nxt  = 4'd1;
                      phase_nxt = 2'd0;
                    end
                  end
                  MODE_PAL8: npix_nxt = 4'd1;
                  MODE_PAL4: npix_nxt = 4'd2;
                  MODE_PAL1: npix_nxt = 4'd8;
                  default: begin
                    if (phase_r == 2'd0) begin
                      part_nxt  = {8'h00, in_data.data_byte};
                      phase_nxt = 2'd1;
                    end else begin
                      npix_nxt  = 4'd1;
                      phase_nxt = 2'd0;
                    end
                  end
                endcase
                state_nxt = (npix_nxt != 4'd0) ? S_PIX : S_END;
              end
            end
            default: ;
          endcase
        end
      end

      S_PIX: begin
        if (col_r < width_r) begin
          mul_a      = row_off;
          mul_b      = DW10;
          pal_ok_nxt = ({1'b0, pidx} < 9'(PALETTE_DEPTH));
          pal_rd_en  = pal_ok_nxt;
          state_nxt  = S_ADDR;
        end else begin
          // columns only grow, so the rest of this byte is past the row
          state_nxt = S_END;
        end
      end

      S_ADDR: begin
        ok_nxt    = idx_ok;
        addr_nxt  = idx[14:0];
        color_nxt = c565;
        if (mode_r == MODE_RGB565) begin
          ch0_nxt = {byte_r[7:3], 3'b000};
          ch1_nxt = {byte_r[2:0], part_r[7:5], 2'b00};
          ch2_nxt = {part_r[4:0], 3'b000};
        end else begin
          ch0_nxt = {3'b000, c565[15:11]};
          ch1_nxt = {2'b00, c565[10:5]};
          ch2_nxt = {3'b000, c565[4:0]};
        end
        cnt_nxt   = 2'd0;
        state_nxt = (idx_ok && dim_r != DIM_FULL) ? S_MUL : S_EMIT;
      end

      S_MUL: begin
        // one channel issued per cycle, product taken from prod_r in the cycle after
        mul_a   = $signed({4'b0000, chsel});
        mul_b   = {2'b00, dim_r};
        cnt_nxt = cnt_r + 2'd1;
        case (cnt_r)
          2'd1: q0_nxt = prod_r[15:8];
          2'd2: q1_nxt = prod_r[15:8];
          2'd3: begin
            if (mode_r == MODE_RGB565) begin
              color_nxt = {q0_r[7:3], q1_r[7:2], prod_r[15:11]};
            end else begin
              color_nxt = {q0_r[4:0], q1_r[5:0], prod_r[12:8]};
            end
            state_nxt = S_EMIT;
          end
          default: ;
        endcase
      end

      S_EMIT: begin
        if (!ok_r || !hold_valid_r || out_free) begin
          if (ok_r) begin
            if (hold_valid_r) begin
              out_valid_nxt = 1'b1;
              out_nxt       = hold_r;
            end
            hold_valid_nxt         = 1'b1;
            hold_nxt.pixel_address = addr_r;
            hold_nxt.pixel_color   = color_r;
            hold_nxt.last_of_run   = 1'b0;
          end
          col_nxt = col_r + 10'd1;
          if (({1'b0, k_r} + 4'd1) < npix_r) begin
            k_nxt     = k_r + 3'd1;
            state_nxt = S_PIX;
          end else begin
            state_nxt = S_END;
          end
        end
      end

      S_END: begin
        if (!hold_valid_r || out_free) begin
          if (hold_valid_r) begin
            out_valid_nxt       = 1'b1;
            out_nxt             = hold_r;
            out_nxt.last_of_run = 1'b1;
            hold_valid_nxt      = 1'b0;
          end
          if ({2'b00, lbc_inc} >= lsize) begin
            lbc_nxt   = 12'd0;
            col_nxt   = 10'd0;
            phase_nxt = 2'd0;
            part_nxt  = 16'd0;
            if (mode_r == MODE_RGB565) begin
              if (({1'b0, row_r} + 11'd1) >= {1'b0, height_r}) begin
                done_nxt = 1'b1;
              end else begin
                row_nxt = row_r + 10'd1;
              end
            end else begin
              if (row_r == 10'd0) begin
                done_nxt = 1'b1;
              end else begin
                row_nxt = row_r - 10'd1;
              end
            end
          end else begin
            lbc_nxt = lbc_inc;
          end
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    prod_nxt = 23'($signed({{11{mul_a[11]}}, mul_a}) * $signed({13'b0, mul_b}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      mode_r       <= MODE_BGR24;
      dim_r        <= DIM_FULL;
      width_r      <= 10'd135;
      height_r     <= 10'd240;
      row_r        <= 10'd0;
      col_r        <= 10'd0;
      lbc_r        <= 12'd0;
      part_r       <= 16'd0;
      phase_r      <= 2'd0;
      done_r       <= 1'b1;
      npix_r       <= 4'd0;
      k_r          <= 3'd0;
      cnt_r        <= 2'd0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      dim_r        <= dim_nxt;
      width_r      <= width_nxt;
      height_r     <= height_nxt;
      row_r        <= row_nxt;
      col_r        <= col_nxt;
      lbc_r        <= lbc_nxt;
      part_r       <= part_nxt;
      phase_r      <= phase_nxt;
      done_r       <= done_nxt;
      npix_r       <= npix_nxt;
      k_r          <= k_nxt;
      cnt_r        <= cnt_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    byte_r   <= byte_nxt;
    prod_r   <= prod_nxt;
    pal_ok_r <= pal_ok_nxt;
    ok_r     <= ok_nxt;
    addr_r   <= addr_nxt;
    color_r  <= color_nxt;
    ch0_r    <= ch0_nxt;
    ch1_r    <= ch1_nxt;
    ch2_r    <= ch2_nxt;
    q0_r     <= q0_nxt;
    q1_r     <= q1_nxt;
    hold_r   <= hold_nxt;
    out_r    <= out_nxt;
  end

  // the pending pixel is always flushed before a new transaction is taken
  a_hold_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !hold_valid_r)
    else $error("pending pixel left behind at end of byte");

  a_pix_in_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PIX) |-> (({1'b0, k_r}) < npix_r))
    else $error("pixel step beyond pixels of byte");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_END && hold_valid_r && out_free) |=>
      (out_valid_r && out_r.last_of_run))
    else $error("final pixel of byte not marked last");

  a_addr_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((FRAME > 32767) || ({17'b0, out_r.pixel_address} < 32'(FRAME))))
    else $error("pixel address outside frame");

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bitmap_pixel_unpacker_top. A queue of commands
// (starts, palette writes, image bytes) feeds a valid/stall driver. Each
// accepted command runs through a cycle-free predictor that keeps its own
// palette, counters and register copies and queues the frame writes due.
// A monitor pops and compares every accepted frame write. Registers change
// only while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpu_pkg::*;

  localparam int DISP_W        = 135;
  localparam int DISP_H        = 240;
  localparam int PAL_DEPTH     = 256;
  localparam int SETTLE_CYCLES = 100;
  localparam int RAND_BYTES    = 90;
  localparam int HOLD_CYCLES   = 600;

  localparam logic [1:0] FUNC_NONE   = 2'd3;
  localparam logic [2:0] MODE_UNUSED = 3'd5;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bitmap_pixel_unpacker_top #(
    .DISPLAY_WIDTH (DISP_W),
    .DISPLAY_HEIGHT(DISP_H),
    .PALETTE_DEPTH (PAL_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  logic [2:0]  cur_mode = MODE_BGR24;
  logic [7:0]  cur_dim  = DIM_FULL;
  logic [9:0]  cur_w    = 10'd135;
  logic [9:0]  cur_h    = 10'd240;

  logic [23:0] pal_mem [PAL_DEPTH];
  logic [10:0] row_q    = '0;
  logic [10:0] col_q    = '0;
  logic [11:0] lbytes_q = '0;
  logic [15:0] part_q   = '0;
  logic [1:0]  phase_q  = '0;
  logic        done_q   = 1'b1;

  out_t run_buf [8];
  int   run_n;
  out_t pixel_writes_due [$];
  in_t  cmd_queue [$];

  logic [7:0] byte_list_bgr [8] = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00};
  logic [7:0] byte_list_raw [8] = '{8'h00, 8'h00, 8'hFF, 8'hFF, 8'h1F, 8'hF8, 8'hE0, 8'h07};

  function automatic logic [15:0] bmp565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [15:0] c;
    int rr, gg, bb;
    c = {r[7:3], g[7:2], b[7:3]};
    if (cur_dim != DIM_FULL) begin
      rr = (int'(c[15:11]) * int'(cur_dim)) >> 8;
      gg = (int'(c[10:5]) * int'(cur_dim)) >> 8;
      bb = (int'(c[4:0]) * int'(cur_dim)) >> 8;
      c  = {rr[4:0], gg[5:0], bb[4:0]};
    end
    return c;
  endfunction

  // raw mode scales the 8-bit expanded channels, then truncates back to 565
  function automatic logic [15:0] raw565(logic [7:0] lo, logic [7:0] hi);
    int r, g, b;
    if (cur_dim == DIM_FULL) return {hi, lo};
    r = (int'(hi & 8'hF8) * int'(cur_dim)) >> 8;
    g = ((((int'(hi) << 5) | (int'(lo) >> 3)) & 'hFC) * int'(cur_dim)) >> 8;
    b = (((int'(lo) << 3) & 'hF8) * int'(cur_dim)) >> 8;
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] pal_pixel(logic [7:0] idx);
    logic [23:0] c;
    c = (int'(idx) < PAL_DEPTH) ? pal_mem[idx] : '0;
    return bmp565(c[23:16], c[15:8], c[7:0]);
  endfunction

  // centered placement; anything outside the frame is dropped
  function automatic void place(logic [10:0] col, logic [15:0] color);
    int xo, yo, idx;
    xo  = (DISP_W - int'(cur_w)) / 2;
    yo  = (DISP_H - int'(cur_h)) / 2;
    idx = (int'(row_q) + yo) * DISP_W + int'(col) + xo;
    if (idx >= 0 && idx < DISP_W * DISP_H) begin
      run_buf[run_n].pixel_address = idx[14:0];
      run_buf[run_n].pixel_color   = color;
      run_buf[run_n].last_of_run   = 1'b0;
      run_n++;
    end
  endfunction

  // bytes per image line, BMP lines padded to four bytes
  function automatic int line_len();
    int bits;
    case (cur_mode)
      MODE_BGR24: bits = 24;
      MODE_PAL8:  bits = 8;
      MODE_PAL4:  bits = 4;
      MODE_PAL1:  bits = 1;
      default:    return int'(cur_w) * 2;
    endcase
    return ((bits * int'(cur_w) + 31) >> 5) * 4;
  endfunction

  function automatic void take_byte(logic [7:0] d);
    case (cur_mode)
      MODE_BGR24: begin
        if (phase_q == 2'd0) begin
          part_q  = {8'h00, d};
          phase_q = 2'd1;
        end else if (phase_q == 2'd1) begin
          part_q  = {d, part_q[7:0]};
          phase_q = 2'd2;
        end else begin
          if (col_q < cur_w) begin
            place(col_q, bmp565(d, part_q[15:8], part_q[7:0]));
            col_q++;
          end
          phase_q = 2'd0;
        end
      end
      MODE_PAL8: begin
        if (col_q < cur_w) begin
          place(col_q, pal_pixel(d));
          col_q++;
        end
      end
      MODE_PAL4: begin
        for (int k = 0; k < 2; k++) begin
          if (col_q < cur_w) begin
            place(col_q, pal_pixel((k == 0) ? {4'h0, d[7:4]} : {4'h0, d[3:0]}));
            col_q++;
          end
        end
      end
      MODE_PAL1: begin
        for (int k = 0; k < 8; k++) begin
          if (col_q < cur_w) begin
            place(col_q, pal_pixel({7'h00, d[7-k]}));
            col_q++;
          end
        end
      end
      default: begin
        if (phase_q == 2'd0) begin
          part_q  = {8'h00, d};
          phase_q = 2'd1;
        end else begin
          if (col_q < cur_w) begin
            place(col_q, raw565(part_q[7:0], d));
            col_q++;
          end
          phase_q = 2'd0;
        end
      end
    endcase

    lbytes_q++;
    if (int'(lbytes_q) >= line_len()) begin
      lbytes_q = '0;
      col_q    = '0;
      phase_q  = 2'd0;
      part_q   = '0;
      if (cur_mode == MODE_RGB565) begin
        if (int'(row_q) + 1 >= int'(cur_h)) done_q = 1'b1;
        else row_q++;
      end else begin
        if (row_q == '0) done_q = 1'b1;
        else row_q--;
      end
    end
  endfunction

  function automatic void unpack_item(in_t it);
    run_n = 0;
    if (cur_mode > MODE_RGB565) return;
    case (it.func)
      FUNC_START: begin
        col_q    = '0;
        lbytes_q = '0;
        part_q   = '0;
        phase_q  = 2'd0;
        if (cur_mode == MODE_RGB565 || cur_h == '0) row_q = '0;
        else row_q = 11'(cur_h) - 11'd1;
        done_q = (cur_w == '0 || cur_h == '0);
      end
      FUNC_PAL_WR: begin
        if (int'(it.palette_index) < PAL_DEPTH) pal_mem[it.palette_index] = it.palette_color;
      end
      FUNC_DATA: begin
        if (!done_q) take_byte(it.data_byte);
      end
      default: ;
    endcase
    if (run_n > 0) run_buf[run_n-1].last_of_run = 1'b1;
    for (int i = 0; i < run_n; i++) pixel_writes_due.push_back(run_buf[i]);
  endfunction

  // ---------------------------------------------------------- driver / monitor
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int bad_count   = 0;
  int hold_left   = 0;
  logic hold_armed = 1'b0;
  logic hold_seen  = 1'b0;

  function automatic void flag_mismatch(string msg);
    bad_count++;
    if (bad_count <= 10) $display("%s", msg);
  endfunction

  always @(posedge clk) begin : driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) unpack_item(in_data);
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= cmd_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the block backs up into its input
  always @(posedge clk) begin : long_hold
    if (hold_armed && !hold_seen) begin
      hold_left <= HOLD_CYCLES;
      hold_seen <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pixel_writes_due.size() == 0) begin
          flag_mismatch($sformatf("unexpected pixel write: addr %0d color %h last %b",
                                  out_data.pixel_address, out_data.pixel_color,
                                  out_data.last_of_run));
        end else begin
          want = pixel_writes_due.pop_front();
          if (out_data.pixel_address !== want.pixel_address ||
              out_data.pixel_color !== want.pixel_color ||
              out_data.last_of_run !== want.last_of_run) begin
            flag_mismatch($sformatf(
              "pixel write mismatch: expected addr %0d color %h last %b, got addr %0d color %h last %b",
              want.pixel_address, want.pixel_color, want.last_of_run,
              out_data.pixel_address, out_data.pixel_color, out_data.last_of_run));
          end
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rx_idle_pct);
    end
  end

  // ---------------------------------------------------------------- stimulus
  bit pal_written [PAL_DEPTH];
  int rand_bytes = 0;

  task automatic send(logic [1:0] func, logic [7:0] d);
    in_t it;
    it.func          = func;
    it.data_byte     = d;
    it.palette_index = 8'($urandom);
    it.palette_color = 24'($urandom);
    if (func == FUNC_PAL_WR) pal_written[it.palette_index] = 1'b1;
    cmd_queue.push_back(it);
  endtask

  task automatic write_entry(logic [7:0] idx, logic [23:0] color);
    in_t it;
    it.func          = FUNC_PAL_WR;
    it.data_byte     = 8'($urandom);
    it.palette_index = idx;
    it.palette_color = color;
    pal_written[idx] = 1'b1;
    cmd_queue.push_back(it);
  endtask

  // palette entries a byte may look up are loaded before the byte goes out
  task automatic send_byte(logic [7:0] d);
    case (cur_mode)
      MODE_PAL8: if (!pal_written[d]) write_entry(d, 24'($urandom));
      MODE_PAL4: begin
        if (!pal_written[{4'h0, d[7:4]}]) write_entry({4'h0, d[7:4]}, 24'($urandom));
        if (!pal_written[{4'h0, d[3:0]}]) write_entry({4'h0, d[3:0]}, 24'($urandom));
      end
      MODE_PAL1: begin
        if (!pal_written[0]) write_entry(8'd0, 24'($urandom));
        if (!pal_written[1]) write_entry(8'd1, 24'($urandom));
      end
      default: ;
    endcase
    send(FUNC_DATA, d);
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || pixel_writes_due.size() != 0);
    // bytes whose pixels all fall off the frame give no sign of completion
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PIXEL_MODE:   cur_mode = val[2:0];
      CFG_DIMMING:      cur_dim  = val[7:0];
      CFG_IMAGE_WIDTH:  cur_w    = val[9:0];
      CFG_IMAGE_HEIGHT: cur_h    = val[9:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [2:0] mode, logic [7:0] dim, logic [9:0] w, logic [9:0] h);
    wait_idle();
    write_reg(CFG_PIXEL_MODE, 10'(mode));
    write_reg(CFG_DIMMING, 10'(dim));
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    @(negedge clk);
  endtask

  task automatic random_image();
    logic [2:0] mode;
    logic [7:0] dim;
    logic [9:0] w, h;
    int n, roll;
    mode = 3'($urandom_range(0, 4));
    dim  = ($urandom_range(1) != 0) ? DIM_FULL : 8'($urandom);
    if ($urandom_range(9) == 0) begin
      w = 10'($urandom_range(9, 24));
      h = 10'd1;
    end else begin
      w = 10'($urandom_range(1, 8));
      h = 10'($urandom_range(1, 3));
    end
    configure(mode, dim, w, h);
    // now and then carry on with the open image under the new settings
    if ($urandom_range(99) >= 10) send(FUNC_START, 8'($urandom));
    n = line_len() * int'(h) + $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) send(FUNC_PAL_WR, 8'($urandom));
      else if (roll < 5) send(FUNC_START, 8'($urandom));
      else if (roll < 6) send(FUNC_NONE, 8'($urandom));
      else send_byte(8'($urandom));
    end
    rand_bytes += n;
  endtask

  initial begin
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    tx_idle_pct = 26;
    rx_idle_pct = 82;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // byte with no image open
    send(FUNC_DATA, 8'hFF);

    // 24-bit: black then white pixel, padding, then a byte past the end
    configure(MODE_BGR24, DIM_FULL, 10'd2, 10'd1);
    send(FUNC_START, 8'h00);
    foreach (byte_list_bgr[i]) send_byte(byte_list_bgr[i]);
    send_byte(8'h55);

    // 8-bit palette at zero brightness, extreme indexes
    configure(MODE_PAL8, 8'd0, 10'd2, 10'd1);
    write_entry(8'hFF, 24'hFFFFFF);
    write_entry(8'h00, 24'h000000);
    send(FUNC_START, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'h00);

    // 4-bit, odd width leaves the last nibble unused
    configure(MODE_PAL4, 8'd128, 10'd3, 10'd1);
    send(FUNC_START, 8'h00);
    send_byte(8'hF0);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h00);

    // 1-bit: a full eight-pixel byte
    configure(MODE_PAL1, DIM_FULL, 10'd9, 10'd1);
    send(FUNC_START, 8'h00);
    send_byte(8'hA5);
    send_byte(8'h80);
    send_byte(8'h00);
    send_byte(8'h00);

    // raw 565, two rows top-down, minimal dimming
    configure(MODE_RGB565, 8'd1, 10'd2, 10'd2);
    send(FUNC_START, 8'h00);
    foreach (byte_list_raw[i]) send_byte(byte_list_raw[i]);

    // largest image: BMP starts below the frame, raw starts above it
    configure(MODE_PAL1, DIM_FULL, 10'd1023, 10'd1023);
    send(FUNC_START, 8'h00);
    send_byte(8'hFF);
    configure(MODE_RGB565, DIM_FULL, 10'd1023, 10'd1023);
    send(FUNC_START, 8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    configure(MODE_PAL1, 8'd254, 10'd1023, 10'd1);
    send(FUNC_START, 8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);

    // unused mode, zero width, unused command: all ignored
    configure(MODE_UNUSED, DIM_FULL, 10'd4, 10'd4);
    send(FUNC_START, 8'h00);
    send(FUNC_DATA, 8'hFF);
    configure(MODE_PAL8, DIM_FULL, 10'd0, 10'd4);
    send(FUNC_START, 8'h00);
    send_byte(8'h00);
    send(FUNC_NONE, 8'hFF);

    for (int third = 0; third < 3; third++) begin
      @(negedge clk);
      case (third)
        0: begin tx_idle_pct = 26; rx_idle_pct = 82; end
        1: begin tx_idle_pct = 82; rx_idle_pct = 26; end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          // long receiver hold-off while the sender keeps offering bytes
          configure(MODE_PAL1, DIM_FULL, 10'd64, 10'd2);
          send(FUNC_START, 8'h00);
          repeat (16) send_byte(8'($urandom));
          hold_armed = 1'b1;
        end
      endcase
      while (rand_bytes < (third + 1) * RAND_BYTES / 3) random_image();
    end

    wait_idle();
    if (pixel_writes_due.size() != 0)
      flag_mismatch($sformatf("%0d pixel writes never arrived", pixel_writes_due.size()));
    if (bad_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
